// File: rtl/core/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CCFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication whose consequent is delayed by the n argument
`define CCFA_ASSERT_DLY(lbl, clk, rst_n, ante, n, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/ccfa_pkg.sv
// shared constants, types and arithmetic helpers for the conic coefficient block
package ccfa_pkg;

	localparam int ANGLE_BITS = 16;
	localparam int QBITS      = ANGLE_BITS - 2;
	localparam int ZSHIFT     = 30 - QBITS;
	localparam int UP         = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
	localparam int DOWN       = (ANGLE_BITS >= 16) ? 0 : 16 - ANGLE_BITS;
	localparam int EXT_W      = 16 + ANGLE_BITS;

	localparam int SIN_W   = 18;
	localparam int COEF_W  = 48;
	localparam int SUM_W   = COEF_W + 2;
	localparam int SIN_LAT = 7;
	localparam int PIPE_LAT = 11;

	localparam logic [31:0] SIN_C1 = 32'd1686629713;
	localparam logic [31:0] SIN_C3 = 32'd693598668;
	localparam logic [31:0] SIN_C5 = 32'd85569306;
	localparam logic [31:0] SIN_C7 = 32'd5026995;
	localparam logic [30:0] SIN_C9 = 31'd172272;

	typedef enum logic [1:0] {
		CMD_ELLIPSE   = 2'd0,
		CMD_HYPERBOLA = 2'd1,
		CMD_PARABOLA  = 2'd2,
		CMD_NONE      = 2'd3
	} cmd_t;

	// product terms, each rounded on its own
	localparam int T_A2SS  = 0;
	localparam int T_B2CC  = 1;
	localparam int T_A2CC  = 2;
	localparam int T_B2SS  = 3;
	localparam int T_A2S2  = 4;
	localparam int T_B2S2  = 5;
	localparam int T_A2AYS = 6;
	localparam int T_B2AXC = 7;
	localparam int T_A2AYC = 8;
	localparam int T_B2AXS = 9;
	localparam int T_AXXB2 = 10;
	localparam int T_AYYA2 = 11;
	localparam int T_A2B2  = 12;
	localparam int T_SS    = 13;
	localparam int T_CC    = 14;
	localparam int T_AYS   = 15;
	localparam int T_PC    = 16;
	localparam int T_AYC   = 17;
	localparam int T_PS    = 18;
	localparam int NTERM   = 19;

	// per-item values that ride along the sine pipeline
	typedef struct packed {
		cmd_t               cmd;
		logic signed [31:0] a2;
		logic signed [31:0] b2;
		logic signed [31:0] axx;
		logic signed [31:0] ayy;
		logic signed [47:0] a2ay;
		logic signed [47:0] b2ax;
		logic signed [15:0] p;
		logic signed [15:0] ay;
		logic signed [33:0] pf;
	} geo_t;

	typedef struct packed {
		cmd_t                     cmd;
		logic signed [SIN_W-1:0]  s2;
		logic signed [33:0]       pf;
	} side_t;

	function automatic int term_shift(int idx);
		int sh;
		sh = 16;
		if (idx <= T_B2SS) sh = 32;
		else if (idx >= T_A2AYS && idx <= T_B2AXS) sh = 23;
		else if (idx >= T_AYS) sh = 7;
		return sh;
	endfunction

	// one horner step: c - (z2 * t) >> 30
	function automatic logic [30:0] horner(logic [30:0] z2, logic [30:0] t, logic [31:0] c);
		logic [61:0] prod;
		prod = 62'(z2) * 62'(t);
		return 31'(c - 32'(prod >> 30));
	endfunction

	// shift right, rounding half away from zero
	function automatic logic signed [COEF_W-1:0] rnd_shr(logic signed [63:0] v, int sh);
		logic [63:0] m;
		m = v[63] ? 64'(-v) : 64'(v);
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return v[63] ? COEF_W'(-m) : COEF_W'(m);
	endfunction

	function automatic logic signed [COEF_W-1:0] sat48(logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'({1'b0, {(COEF_W-1){1'b1}}});
		lo = -hi - SUM_W'(1);
		if (v > hi) return COEF_W'(hi);
		if (v < lo) return COEF_W'(lo);
		return COEF_W'(v);
	endfunction

endpackage

// File: rtl/core/ccfa_sine.sv
// pipelined quarter-wave polynomial sine, one phase per cycle
module ccfa_sine (
	input  logic                            clk,
	input  logic [ccfa_pkg::ANGLE_BITS-1:0] phase,
	output logic signed [ccfa_pkg::SIN_W-1:0] sine
);
	import ccfa_pkg::*;

	logic [QBITS:0]  xf;
	logic [30:0]     z_s1, z_s2, z_s3, z_s4, z_s5, z_s6;
	logic [30:0]     z2_s2, z2_s3, z2_s4, z2_s5;
	logic [30:0]     t_s3, t_s4, t_s5, t_s6;
	logic            neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [61:0]     zz;
	logic [61:0]     zt;
	logic [31:0]     r;
	logic [31:0]     rr;
	logic [SIN_W-1:0] mag;

	// fold into the first quadrant
	always_comb begin
		if (phase[QBITS])
			xf = (QBITS+1)'(1 << QBITS) - (QBITS+1)'(phase[QBITS-1:0]);
		else
			xf = (QBITS+1)'(phase[QBITS-1:0]);
	end

	assign zz = 62'(z_s1) * 62'(z_s1);
	assign zt = 62'(z_s6) * 62'(t_s6);
	assign r  = 32'(zt >> 30);
	assign rr = (r + 32'd8192) >> 14;
	assign mag = (rr > 32'd65536) ? SIN_W'(65536) : SIN_W'(rr);

	always_ff @(posedge clk) begin
		z_s1   <= 31'(xf) << ZSHIFT;
		neg_s1 <= phase[ANGLE_BITS-1];
		z2_s2  <= 31'(zz >> 30);
		z_s2   <= z_s1;
		neg_s2 <= neg_s1;
		t_s3   <= horner(z2_s2, SIN_C9, SIN_C7);
		z2_s3  <= z2_s2;
		z_s3   <= z_s2;
		neg_s3 <= neg_s2;
		t_s4   <= horner(z2_s3, t_s3, SIN_C5);
		z2_s4  <= z2_s3;
		z_s4   <= z_s3;
		neg_s4 <= neg_s3;
		t_s5   <= horner(z2_s4, t_s4, SIN_C3);
		z2_s5  <= z2_s4;
		z_s5   <= z_s4;
		neg_s5 <= neg_s4;
		t_s6   <= horner(z2_s5, t_s5, SIN_C1);
		z_s6   <= z_s5;
		neg_s6 <= neg_s5;
		sine   <= neg_s6 ? -$signed(mag) : $signed(mag);
	end

endmodule

// File: rtl/core/conic_coefficients_from_axes_top.sv
// top level: canonical conic to general-form coefficients, fully pipelined
//
// one curve enters on every cycle that start is high (busy never rises), and its
// six coefficients appear at the output registers for one cycle with done high; the
// receiver cannot hold results off, so done must be taken when it shows. the
// pipeline runs through the sine unit, a seven-stage horner chain of 31x31
// multiplies, followed by the square stage, the product stage, the rounding
// stage and the summing/saturation stage. sine, cosine and the sine of the
// doubled angle run in three parallel copies of that unit.
module conic_coefficients_from_axes_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          cmd,
	input  logic signed [15:0]                  semi_a,
	input  logic signed [15:0]                  semi_b,
	input  logic signed [15:0]                  focal_param,
	input  logic signed [15:0]                  offset_x,
	input  logic signed [15:0]                  offset_y,
	input  logic [15:0]                         angle,
	output logic                                done,
	output logic signed [ccfa_pkg::COEF_W-1:0]  coef_xx,
	output logic signed [ccfa_pkg::COEF_W-1:0]  coef_xy,
	output logic signed [ccfa_pkg::COEF_W-1:0]  coef_yy,
	output logic signed [ccfa_pkg::COEF_W-1:0]  coef_x,
	output logic signed [ccfa_pkg::COEF_W-1:0]  coef_y,
	output logic signed [ccfa_pkg::COEF_W-1:0]  coef_const
);
	import ccfa_pkg::*;

	// valid bit per stage, travels with the data
	logic [PIPE_LAT:1] vld_q;
	logic              take;

	// phases for sine, cosine and doubled angle
	logic [ANGLE_BITS-1:0] ph_s, ph_c, ph_2;
	logic signed [SIN_W-1:0] sin_s7, cos_s7, sin2_s7;

	// stage 1 and 2 input registers
	cmd_t               cmd_s1, cmd_s2;
	logic signed [15:0] a_s1, b_s1, p_s1, ax_s1, ay_s1;
	logic signed [15:0] p_s2, ax_s2, ay_s2;
	logic signed [31:0] a2_s2, b2_s2, axx_s2, ayy_s2;

	geo_t geo_s3, geo_s4, geo_s5, geo_s6, geo_s7, geo_s8;
	logic signed [SIN_W-1:0] s_s8, c_s8, s2_s8;
	logic signed [33:0]      ss_s8, cc_s8;

	logic signed [63:0]      prod_s9 [NTERM];
	side_t                   side_s9, side_s10;
	logic signed [COEF_W-1:0] term_s10 [NTERM];

	logic signed [SUM_W-1:0] t [NTERM];
	logic signed [SUM_W-1:0] sxx, sxy, syy, sx, sy, sc;

	assign busy = 1'b0;
	assign take = start & ~busy;
	assign done = vld_q[PIPE_LAT];

	// angle scaled to the phase width, then the two derived phases
	assign ph_s = ANGLE_BITS'((EXT_W'(angle) << UP) >> DOWN);
	assign ph_c = ph_s + ANGLE_BITS'(1 << QBITS);
	assign ph_2 = ph_s << 1;

	ccfa_sine u_sin  (.clk(clk), .phase(ph_s), .sine(sin_s7));
	ccfa_sine u_cos  (.clk(clk), .phase(ph_c), .sine(cos_s7));
	ccfa_sine u_sin2 (.clk(clk), .phase(ph_2), .sine(sin2_s7));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[PIPE_LAT-1:1], take};
		end
	end

	// squares and the products that only need the inputs
	always_ff @(posedge clk) begin
		cmd_s1 <= cmd_t'(cmd);
		a_s1   <= semi_a;
		b_s1   <= semi_b;
		p_s1   <= focal_param;
		ax_s1  <= offset_x;
		ay_s1  <= offset_y;

		cmd_s2 <= cmd_s1;
		a2_s2  <= 32'(a_s1) * 32'(a_s1);
		b2_s2  <= 32'(b_s1) * 32'(b_s1);
		axx_s2 <= 32'(ax_s1) * 32'(ax_s1);
		ayy_s2 <= 32'(ay_s1) * 32'(ay_s1);
		p_s2   <= p_s1;
		ax_s2  <= ax_s1;
		ay_s2  <= ay_s1;

		geo_s3.cmd  <= cmd_s2;
		geo_s3.a2   <= a2_s2;
		geo_s3.b2   <= b2_s2;
		geo_s3.axx  <= axx_s2;
		geo_s3.ayy  <= ayy_s2;
		geo_s3.a2ay <= 48'(a2_s2) * 48'(ay_s2);
		geo_s3.b2ax <= 48'(b2_s2) * 48'(ax_s2);
		geo_s3.p    <= p_s2;
		geo_s3.ay   <= ay_s2;
		// parabola constant term, exact
		geo_s3.pf   <= 34'(ayy_s2) - ((34'(p_s2) * 34'(ax_s2)) <<< 1);

		// wait for the sine units
		geo_s4 <= geo_s3;
		geo_s5 <= geo_s4;
		geo_s6 <= geo_s5;
		geo_s7 <= geo_s6;
	end

	// squares of the sine and cosine
	always_ff @(posedge clk) begin
		geo_s8 <= geo_s7;
		s_s8   <= sin_s7;
		c_s8   <= cos_s7;
		s2_s8  <= sin2_s7;
		ss_s8  <= 34'(sin_s7) * 34'(sin_s7);
		cc_s8  <= 34'(cos_s7) * 34'(cos_s7);
	end

	// exact products, one multiplier each; the two square terms are passed through
	always_ff @(posedge clk) begin
		prod_s9[T_A2SS]  <= 64'(geo_s8.a2) * 64'(ss_s8);
		prod_s9[T_B2CC]  <= 64'(geo_s8.b2) * 64'(cc_s8);
		prod_s9[T_A2CC]  <= 64'(geo_s8.a2) * 64'(cc_s8);
		prod_s9[T_B2SS]  <= 64'(geo_s8.b2) * 64'(ss_s8);
		prod_s9[T_A2S2]  <= 64'(geo_s8.a2) * 64'(s2_s8);
		prod_s9[T_B2S2]  <= 64'(geo_s8.b2) * 64'(s2_s8);
		prod_s9[T_A2AYS] <= 64'(geo_s8.a2ay) * 64'(s_s8);
		prod_s9[T_B2AXC] <= 64'(geo_s8.b2ax) * 64'(c_s8);
		prod_s9[T_A2AYC] <= 64'(geo_s8.a2ay) * 64'(c_s8);
		prod_s9[T_B2AXS] <= 64'(geo_s8.b2ax) * 64'(s_s8);
		prod_s9[T_AXXB2] <= 64'(geo_s8.axx) * 64'(geo_s8.b2);
		prod_s9[T_AYYA2] <= 64'(geo_s8.ayy) * 64'(geo_s8.a2);
		prod_s9[T_A2B2]  <= 64'(geo_s8.a2) * 64'(geo_s8.b2);
		prod_s9[T_SS]    <= 64'(ss_s8);
		prod_s9[T_CC]    <= 64'(cc_s8);
		prod_s9[T_AYS]   <= 64'(geo_s8.ay) * 64'(s_s8);
		prod_s9[T_PC]    <= 64'(geo_s8.p) * 64'(c_s8);
		prod_s9[T_AYC]   <= 64'(geo_s8.ay) * 64'(c_s8);
		prod_s9[T_PS]    <= 64'(geo_s8.p) * 64'(s_s8);
		side_s9.cmd <= geo_s8.cmd;
		side_s9.s2  <= s2_s8;
		side_s9.pf  <= geo_s8.pf;
	end

	// each term rounded on its own, half away from zero
	always_ff @(posedge clk) begin
		for (int i = 0; i < NTERM; i++) begin
			term_s10[i] <= rnd_shr(prod_s9[i], term_shift(i));
		end
		side_s10 <= side_s9;
	end

	// sums by curve kind
	always_comb begin
		for (int i = 0; i < NTERM; i++) begin
			t[i] = SUM_W'(term_s10[i]);
		end
		unique case (side_s10.cmd)
			CMD_ELLIPSE: begin
				sxx = t[T_A2SS] + t[T_B2CC];
				sxy = t[T_A2S2] - t[T_B2S2];
				syy = t[T_A2CC] + t[T_B2SS];
				sx  = t[T_A2AYS] + t[T_B2AXC];
				sy  = t[T_A2AYC] - t[T_B2AXS];
				sc  = t[T_AXXB2] + t[T_AYYA2] - t[T_A2B2];
			end
			CMD_HYPERBOLA: begin
				sxx = t[T_B2CC] - t[T_A2SS];
				sxy = -t[T_A2S2] - t[T_B2S2];
				syy = t[T_B2SS] - t[T_A2CC];
				sx  = t[T_B2AXC] - t[T_A2AYS];
				sy  = -t[T_A2AYC] - t[T_B2AXS];
				sc  = t[T_AXXB2] - t[T_AYYA2] - t[T_A2B2];
			end
			CMD_PARABOLA: begin
				sxx = t[T_SS];
				sxy = SUM_W'(side_s10.s2);
				syy = t[T_CC];
				sx  = t[T_AYS] - t[T_PC];
				sy  = t[T_AYC] + t[T_PS];
				sc  = SUM_W'(side_s10.pf);
			end
			CMD_NONE: begin
				// unused kind gives all-zero coefficients
				sxx = '0;
				sxy = '0;
				syy = '0;
				sx  = '0;
				sy  = '0;
				sc  = '0;
			end
		endcase
	end

	// output registers, saturated to 48 bits
	always_ff @(posedge clk) begin
		coef_xx    <= sat48(sxx);
		coef_xy    <= sat48(sxy);
		coef_yy    <= sat48(syy);
		coef_x     <= sat48(sx);
		coef_y     <= sat48(sy);
		coef_const <= sat48(sc);
	end

endmodule

// File: rtl/core/ccfa_checker.sv
// port-level checks for the conic coefficient block, bound to the top level
`include "assert_macros.svh"

module ccfa_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               start,
	input logic                               busy,
	input logic [1:0]                         cmd,
	input logic [15:0]                        angle,
	input logic                               done,
	input logic signed [ccfa_pkg::COEF_W-1:0] coef_xx,
	input logic signed [ccfa_pkg::COEF_W-1:0] coef_xy,
	input logic signed [ccfa_pkg::COEF_W-1:0] coef_yy,
	input logic signed [ccfa_pkg::COEF_W-1:0] coef_x,
	input logic signed [ccfa_pkg::COEF_W-1:0] coef_y,
	input logic signed [ccfa_pkg::COEF_W-1:0] coef_const
);
	import ccfa_pkg::*;

	`CCFA_ASSERT_DLY(a_xfer_done, clk, arst_n, start && !busy, PIPE_LAT, done)
	`CCFA_ASSERT_IMP(a_done_src, clk, arst_n, done, $past(start && !busy, PIPE_LAT))
	`CCFA_ASSERT_DLY(a_none_zero, clk, arst_n, start && !busy && cmd == CMD_NONE, PIPE_LAT, coef_xx == 0 && coef_xy == 0 && coef_yy == 0 && coef_x == 0 && coef_y == 0 && coef_const == 0)
	`CCFA_ASSERT_DLY(a_par_flat, clk, arst_n, start && !busy && cmd == CMD_PARABOLA && angle == 0, PIPE_LAT, coef_xy == 0)

endmodule

bind conic_coefficients_from_axes_top ccfa_checker u_ccfa_checker (.*);

// File: bench/conic_coefficients_checker.sv
// checker for the conic coefficient block: predicts coefficients and compares results
`timescale 1ns / 1ps

module conic_coefficients_checker
	import ccfa_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] semi_a,
	input  logic signed [15:0] semi_b,
	input  logic signed [15:0] focal_param,
	input  logic signed [15:0] offset_x,
	input  logic signed [15:0] offset_y,
	input  logic [15:0]        angle,
	input  logic               done,
	input  logic signed [47:0] coef_xx,
	input  logic signed [47:0] coef_xy,
	input  logic signed [47:0] coef_yy,
	input  logic signed [47:0] coef_x,
	input  logic signed [47:0] coef_y,
	input  logic signed [47:0] coef_const,
	output int                 errors,
	output int                 pending
);

	typedef struct {
		logic signed [47:0] xx, xy, yy, x, y, k;
	} coefs_t;

	coefs_t coef_q[$];

	function automatic longint unsigned magn(longint v);
		return (v < 0) ? -v : v;
	endfunction

	// product shifted right, rounded half away from zero
	function automatic longint rnd_prod(longint x, longint y, int sh);
		longint unsigned m;
		m = magn(x) * magn(y);
		m = (m + (64'd1 << (sh - 1))) >> sh;
		return ((x < 0) != (y < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic logic signed [47:0] clip48(longint v);
		longint hi;
		hi = 64'h0000_7FFF_FFFF_FFFF;
		if (v > hi) return hi[47:0];
		if (v < -hi - 1) return 48'h8000_0000_0000;
		return v[47:0];
	endfunction

	// quarter-wave odd polynomial sine, Q16
	function automatic longint sine16(longint unsigned ph);
		int qb;
		longint unsigned quarter, q, x, z, z2, t, r;
		qb = ANGLE_BITS - 2;
		quarter = 64'd1 << qb;
		q = (ph >> qb) & 3;
		x = ph & (quarter - 1);
		if (q[0]) x = quarter - x;
		z = x << (30 - qb);
		z2 = (z * z) >> 30;
		t = SIN_C9;
		t = SIN_C7 - ((z2 * t) >> 30);
		t = SIN_C5 - ((z2 * t) >> 30);
		t = SIN_C3 - ((z2 * t) >> 30);
		t = SIN_C1 - ((z2 * t) >> 30);
		r = (z * t) >> 30;
		r = (r + (64'd1 << 13)) >> 14;
		if (r > 65536) r = 65536;
		return q[1] ? -longint'(r) : longint'(r);
	endfunction

	function automatic coefs_t conic_coefs(cmd_t kind, longint a, longint b, longint p,
			longint ax, longint ay, logic [15:0] ang);
		longint unsigned mask, ph;
		longint s, c, s2, ss, cc, a2, b2;
		longint r[6];
		coefs_t o;
		mask = (64'd1 << ANGLE_BITS) - 1;
		ph = ((longint'(ang) << UP) >> DOWN) & mask;
		s = sine16(ph);
		c = sine16((ph + (64'd1 << (ANGLE_BITS - 2))) & mask);
		s2 = sine16((ph << 1) & mask);
		ss = s * s;
		cc = c * c;
		a2 = a * a;
		b2 = b * b;
		r = '{default: 0};
		case (kind)
			CMD_ELLIPSE: begin
				r[0] = rnd_prod(a2, ss, 32) + rnd_prod(b2, cc, 32);
				r[1] = rnd_prod(a2, s2, 16) - rnd_prod(b2, s2, 16);
				r[2] = rnd_prod(a2, cc, 32) + rnd_prod(b2, ss, 32);
				r[3] = rnd_prod(a2 * ay, s, 23) + rnd_prod(b2 * ax, c, 23);
				r[4] = rnd_prod(a2 * ay, c, 23) - rnd_prod(b2 * ax, s, 23);
				r[5] = rnd_prod(ax * ax, b2, 16) + rnd_prod(ay * ay, a2, 16)
					- rnd_prod(a2, b2, 16);
			end
			CMD_HYPERBOLA: begin
				r[0] = rnd_prod(b2, cc, 32) - rnd_prod(a2, ss, 32);
				r[1] = -rnd_prod(a2, s2, 16) - rnd_prod(b2, s2, 16);
				r[2] = rnd_prod(b2, ss, 32) - rnd_prod(a2, cc, 32);
				r[3] = rnd_prod(b2 * ax, c, 23) - rnd_prod(a2 * ay, s, 23);
				r[4] = -rnd_prod(a2 * ay, c, 23) - rnd_prod(b2 * ax, s, 23);
				r[5] = rnd_prod(ax * ax, b2, 16) - rnd_prod(ay * ay, a2, 16)
					- rnd_prod(a2, b2, 16);
			end
			CMD_PARABOLA: begin
				r[0] = rnd_prod(ss, 1, 16);
				r[1] = s2;
				r[2] = rnd_prod(cc, 1, 16);
				r[3] = rnd_prod(ay, s, 7) - rnd_prod(p, c, 7);
				r[4] = rnd_prod(ay, c, 7) + rnd_prod(p, s, 7);
				r[5] = ay * ay - 2 * p * ax;
			end
			default: ;
		endcase
		o.xx = clip48(r[0]);
		o.xy = clip48(r[1]);
		o.yy = clip48(r[2]);
		o.x = clip48(r[3]);
		o.y = clip48(r[4]);
		o.k = clip48(r[5]);
		return o;
	endfunction

	task automatic cmp(string name, logic signed [47:0] want, logic signed [47:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	initial begin
		errors = 0;
		pending = 0;
	end

	always @(posedge clk) begin
		coefs_t w;
		if (arst_n) begin
			if (start && !busy)
				coef_q.push_back(conic_coefs(cmd_t'(cmd), semi_a, semi_b, focal_param,
					offset_x, offset_y, angle));
			if (done) begin
				if (coef_q.size() == 0) begin
					$error("result with no transfer outstanding");
					errors++;
				end else begin
					w = coef_q.pop_front();
					cmp("coef_xx", w.xx, coef_xx);
					cmp("coef_xy", w.xy, coef_xy);
					cmp("coef_yy", w.yy, coef_yy);
					cmp("coef_x", w.x, coef_x);
					cmp("coef_y", w.y, coef_y);
					cmp("coef_const", w.k, coef_const);
				end
			end
			pending = coef_q.size();
		end
	end

endmodule

// File: bench/tb.sv
// testbench top: stimulus, clock, reset and verdict for the conic coefficient block
`timescale 1ns / 1ps

module tb;
	import ccfa_pkg::*;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         cmd;
	logic signed [15:0] semi_a, semi_b, focal_param, offset_x, offset_y;
	logic [15:0]        angle;
	logic               done;
	logic signed [47:0] coef_xx, coef_xy, coef_yy, coef_x, coef_y, coef_const;
	int                 errors;
	int                 pending;
	int                 sent;

	conic_coefficients_from_axes_top dut (.*);

	conic_coefficients_checker chk (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	// field values biased toward the extremes now and then
	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 9))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'(int'($urandom_range(0, 1023)) - 512);
			default: return 16'($urandom);
		endcase
	endfunction

	// present one curve and hold it until the transfer happens; then maybe idle a while
	task automatic put_curve(cmd_t k, logic [15:0] a, logic [15:0] b, logic [15:0] p,
			logic [15:0] ax, logic [15:0] ay, logic [15:0] ang, int idle_pct);
		start = 1'b1;
		cmd = k;
		semi_a = a;
		semi_b = b;
		focal_param = p;
		offset_x = ax;
		offset_y = ay;
		angle = ang;
		while (busy) @(negedge clk);
		@(negedge clk);
		sent++;
		// a run of idle cycles, sometimes long, sometimes none
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			angle = 16'($urandom);
			@(negedge clk);
		end
	endtask

	task automatic drain();
		start = 1'b0;
		wait (pending == 0);
		repeat (PIPE_LAT + 4) @(negedge clk);
	endtask

	initial begin
		int idle;
		cmd_t k;
		start = 1'b0;
		cmd = CMD_ELLIPSE;
		semi_a = '0;
		semi_b = '0;
		focal_param = '0;
		offset_x = '0;
		offset_y = '0;
		angle = '0;
		sent = 0;
		arst_n = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: each kind at one cardinal angle, then the extremes
		for (int i = 0; i < 4; i++) begin
			k = cmd_t'(i);
			put_curve(k, 16'h0300, 16'h0200, 16'h0100, 16'h0080, 16'hFF40,
				16'(i * 16384), 0);
		end
		put_curve(CMD_ELLIPSE, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 0);
		put_curve(CMD_ELLIPSE, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h2000, 0);
		put_curve(CMD_HYPERBOLA, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h6000, 0);
		put_curve(CMD_HYPERBOLA, 16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h4000, 0);
		put_curve(CMD_PARABOLA, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'hC000, 0);
		put_curve(CMD_PARABOLA, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 0);
		put_curve(CMD_PARABOLA, 16'h1234, 16'h4321, 16'h8000, 16'h8000, 16'h0000, 16'hFFFF, 0);
		put_curve(CMD_NONE, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1234, 0);
		put_curve(CMD_ELLIPSE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 0);
		put_curve(CMD_ELLIPSE, 16'hFD00, 16'h0300, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 0);
		put_curve(CMD_HYPERBOLA, 16'h0300, 16'hFE00, 16'h0000, 16'h0100, 16'hFF00, 16'h3FFF, 0);
		// let the pipe empty before the random part
		drain();

		// random: sender idles now and then, then most of the time, then never
		for (int ph = 0; ph < 3; ph++) begin
			idle = (ph == 0) ? 25 : (ph == 1) ? 86 : 0;
			for (int n = 0; n < 680; n++)
				put_curve(cmd_t'($urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2)),
					pick16(), pick16(), pick16(), pick16(), pick16(),
					16'($urandom), idle);
			drain();
		end

		$display("covered %0d curve transfers: all kinds incl. unused code, axis and angle",
			sent);
		$display("extremes, idle sender at 25%% / 86%% / none, pipe drained between phases");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
